>>> hw/rtl/att_pkg.sv
// types, constants and helpers shared by the averaged threshold trigger
`default_nettype none

package att_pkg;

  localparam int unsigned MAX_WINDOW  = 1024;
  localparam int unsigned SAMPLE_BITS = 10;

  localparam int unsigned SUM_W  = 20;
  localparam int unsigned CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned TIME_W = 32;
  localparam int unsigned PCT_W  = 7;
  localparam int unsigned AVG_W  = 10;
  localparam int unsigned STEP_W = $clog2(SUM_W);

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WINDOW);
  localparam logic [SUM_W-1:0] AVG_MAX = SUM_W'((1 << SAMPLE_BITS) - 1);
  localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

  // level = (pct * avg) / 100 done as a multiply by a scaled reciprocal
  localparam int unsigned PROD_W  = PCT_W + AVG_W;
  localparam int unsigned RECIP_S = 24;
  localparam int unsigned RECIP_W = 18;
  localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(((1 << RECIP_S) + 99) / 100);
  localparam int unsigned SCL_W   = PROD_W + RECIP_W;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [0:0] {
    CFG_PERCENT = 1'b0,
    CFG_DELAY   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic              cal;
    logic [TIME_W-1:0] now;
    logic [CNT_W-1:0]  count;
    logic [SUM_W-1:0]  sum;
  } win_t;

  typedef struct packed {
    logic [PCT_W-1:0]  percent;
    logic [TIME_W-1:0] delay;
  } cfg_t;

  typedef struct packed {
    logic [AVG_W-1:0] threshold;
    logic             below;
    logic             triggered;
    logic [AVG_W-1:0] average;
  } res_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_MUL,
    B_RECIP,
    B_DONE
  } back_state_e;

endpackage

`default_nettype wire

>>> hw/rtl/att_front.sv
// front end: sample accumulation and window framing
`default_nettype none

module att_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [att_pkg::SAMPLE_BITS-1:0] sample_i,
  input  wire logic                      last_i,
  input  wire logic                      cal_i,
  input  wire logic [att_pkg::TIME_W-1:0] now_i,
  output logic                           push_o,
  output att_pkg::win_t                  win_o,
  input  wire logic                      full_i
);
  import att_pkg::*;

  logic [SUM_W-1:0] sum_q, sum_d, sum_acc;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_acc;
  logic [SUM_W:0]   sum_ext;
  logic             accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    sum_ext = {1'b0, sum_q} + (SUM_W + 1)'(sample_i);
    if (cnt_q >= CNT_MAX) begin
      sum_acc = sum_q;
      cnt_acc = cnt_q;
    end else begin
      sum_acc = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
      cnt_acc = cnt_q + CNT_W'(1);
    end
  end

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (accept) begin
      if (last_i) begin
        sum_d = '0;
        cnt_d = '0;
      end else begin
        sum_d = sum_acc;
        cnt_d = cnt_acc;
      end
    end
  end

  assign push_o    = accept && last_i;
  assign win_o.cal   = cal_i;
  assign win_o.now   = now_i;
  assign win_o.count = cnt_acc;
  assign win_o.sum   = sum_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/att_fifo.sv
// short window queue between front end and back end
`default_nettype none

module att_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  att_pkg::win_t      data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output att_pkg::win_t      data_o,
  output logic               empty_o
);
  import att_pkg::*;

  win_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? wr_q + FIFO_PTR_W'(1) : wr_q;
    rd_d  = do_pop ? rd_q + FIFO_PTR_W'(1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + FIFO_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/att_back.sv
// back end: shift-subtract average, threshold scaling, trigger decision, result register
`default_nettype none

module att_back (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  att_pkg::cfg_t   cfg_i,
  input  att_pkg::win_t   win_i,
  input  wire logic       empty_i,
  output logic            pop_o,
  output logic            res_valid_o,
  input  wire logic       res_ready_i,
  output att_pkg::res_t   res_o
);
  import att_pkg::*;

  back_state_e state_q, state_d;

  logic              cal_q;
  logic [TIME_W-1:0] now_q;
  logic [CNT_W-1:0]  div_q;
  logic [SUM_W-1:0]  dvd_q, dvd_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [STEP_W-1:0] step_q;
  logic [AVG_W-1:0]  avg_q, avg_c;
  logic [PROD_W-1:0] prod_q;
  logic [SCL_W-1:0]  scl_q;
  logic [AVG_W-1:0]  level_q, level_d;
  logic [TIME_W-1:0] last_q, last_d;
  logic [PCT_W-1:0]  pct_c;
  logic [CNT_W:0]    rem_sh, rem_sub;
  logic [TIME_W-1:0] elapsed;
  logic              below_c, trig_c;
  logic              out_load, load_win, div_done;
  logic              vld_q, vld_d;
  res_t              res_q, res_d;

  // one quotient bit per cycle
  always_comb begin
    rem_sh  = {rem_q, dvd_q[SUM_W-1]};
    rem_sub = rem_sh - {1'b0, div_q};
    if (rem_sh >= {1'b0, div_q}) begin
      rem_d = rem_sub[CNT_W-1:0];
      dvd_d = {dvd_q[SUM_W-2:0], 1'b1};
    end else begin
      rem_d = rem_sh[CNT_W-1:0];
      dvd_d = {dvd_q[SUM_W-2:0], 1'b0};
    end
  end

  assign div_done = (step_q == STEP_W'(SUM_W - 1));
  assign avg_c    = (dvd_q > AVG_MAX) ? AVG_MAX[AVG_W-1:0] : dvd_q[AVG_W-1:0];
  assign pct_c    = (cfg_i.percent > PCT_FULL) ? PCT_FULL : cfg_i.percent;
  assign elapsed  = now_q - last_q;
  assign below_c  = (avg_q <= level_q);
  assign trig_c   = below_c && (elapsed > cfg_i.delay);

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:  if (!empty_i) state_d = B_DIV;
      B_DIV:   if (div_done) state_d = B_MUL;
      B_MUL:   state_d = B_RECIP;
      B_RECIP: state_d = B_DONE;
      B_DONE:  if (!vld_q || res_ready_i) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    load_win = 1'b0;
    out_load = 1'b0;
    case (state_q)
      B_IDLE: begin
        pop_o    = !empty_i;
        load_win = !empty_i;
      end
      B_DONE:  out_load = !vld_q || res_ready_i;
      default: ;
    endcase
  end

  always_comb begin
    level_d = level_q;
    last_d  = last_q;
    res_d   = res_q;
    if (out_load) begin
      res_d.average = avg_q;
      if (cal_q) begin
        level_d         = scl_q[RECIP_S +: AVG_W];
        res_d.triggered = 1'b0;
        res_d.below     = 1'b0;
        res_d.threshold = scl_q[RECIP_S +: AVG_W];
      end else begin
        res_d.triggered = trig_c;
        res_d.below     = below_c;
        res_d.threshold = level_q;
        if (trig_c) begin
          last_d = now_q;
        end
      end
    end
    vld_d = out_load || (vld_q && !res_ready_i);
  end

  always_ff @(posedge clk_i) begin
    if (load_win) begin
      cal_q  <= win_i.cal;
      now_q  <= win_i.now;
      div_q  <= win_i.count;
      dvd_q  <= win_i.sum;
      rem_q  <= '0;
      step_q <= '0;
    end else if (state_q == B_DIV) begin
      dvd_q  <= dvd_d;
      rem_q  <= rem_d;
      step_q <= step_q + STEP_W'(1);
    end
    if (state_q == B_MUL) begin
      avg_q  <= avg_c;
      prod_q <= PROD_W'(pct_c) * PROD_W'(avg_c);
    end
    if (state_q == B_RECIP) begin
      scl_q <= SCL_W'(prod_q) * SCL_W'(RECIP_K);
    end
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      level_q <= '0;
      last_q  <= '0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      level_q <= level_d;
      last_q  <= last_d;
      vld_q   <= vld_d;
    end
  end

  assign res_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

>>> hw/rtl/averaged_threshold_trigger.sv
// top level of the averaged threshold trigger
// throughput: one sample per cycle while the window queue is not full; the back end
// takes one window at a time in a one-bit-per-cycle divider, so closely spaced window
// ends stall input; results are registered after the divide, multiply and scale steps
// two window entries queue between front and back end
// reset: asynchronous active low; sum, count, level and last trigger time clear
`default_nettype none

module averaged_threshold_trigger (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // sample, now_ms
  input  wire logic        s_axis_tlast,
  input  wire logic [0:0]  s_axis_tuser,   // calibrate
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // average, threshold
  output logic [1:0]       m_axis_tuser,   // triggered, below_threshold
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  import att_pkg::*;

  cfg_t cfg_q, cfg_d;
  win_t win_push, win_pop;
  res_t res;
  logic push, pop, fifo_full, fifo_empty;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PERCENT: cfg_d.percent = cfg_data_i[PCT_W-1:0];
        CFG_DELAY:   cfg_d.delay   = cfg_data_i[TIME_W-1:0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  att_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sample_i   (s_axis_tdata[SAMPLE_BITS-1:0]),
    .last_i     (s_axis_tlast),
    .cal_i      (s_axis_tuser[0]),
    .now_i      (s_axis_tdata[SAMPLE_BITS +: TIME_W]),
    .push_o     (push),
    .win_o      (win_push),
    .full_i     (fifo_full)
  );

  att_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (win_push),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .data_o  (win_pop),
    .empty_o (fifo_empty)
  );

  att_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .win_i       (win_pop),
    .empty_i     (fifo_empty),
    .pop_o       (pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {4'b0, res.threshold, res.average};
  assign m_axis_tuser = {res.below, res.triggered};

  a_trig_below : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[1])
    else $error("trigger reported above threshold");

  a_trig_level : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[9:0] <= m_axis_tdata[19:10])
    else $error("triggered average exceeds threshold");

  a_full_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_full |-> !s_axis_tready)
    else $error("input taken while window queue full");

endmodule

`default_nettype wire
